// ----- hdl/glcm_pkg.sv -----
// Shared types and constants for the co-occurrence accumulator.
// No dependencies; used by glcm_sat_add and the top level.
package glcm_pkg;

    localparam int CFG_BITS         = 11;
    localparam int FIELD_LEVEL_BITS = 8;
    localparam int FIELD_COUNT_BITS = 32;
    localparam int WIDTH_RESET      = 256;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // increment applied to one count cell: one per pair side, two when both levels of the pair are equal
    typedef logic [1:0] inc_t;

    localparam inc_t INC_ONE = 2'd1;
    localparam inc_t INC_TWO = 2'd2;

endpackage

// ----- hdl/glcm_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies; holds the count matrix and the previous image row.
module glcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/glcm_sat_add.sv -----
// Saturating incrementer shared by every count update.
// Depends on glcm_pkg for the increment type.
module glcm_sat_add #(
    parameter int COUNT_BITS = 32
) (
    input  logic [COUNT_BITS-1:0] value,
    input  glcm_pkg::inc_t        inc,
    output logic [COUNT_BITS-1:0] sum
);

    localparam int SUM_BITS = COUNT_BITS + 1;

    logic [SUM_BITS-1:0] wide;

    // carry out means the count went past its maximum: pin it there
    assign wide = {1'b0, value} + SUM_BITS'(inc);
    assign sum  = wide[COUNT_BITS] ? '1 : wide[COUNT_BITS-1:0];

endmodule

// ----- hdl/glcm_cooccurrence_accumulator_unit.sv -----
// Symmetric four-direction grey-level co-occurrence accumulator, top level.
// Depends on glcm_pkg, glcm_ram and glcm_sat_add.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: push a pixel in
//   raster order, read one matrix cell, or clear and start a new image.
//   Output channel (out_valid/out_ready) returns cell_count and max_level, once
//   for each read item and never for other commands.
//   cfg_we/cfg_data write image_width; write it only while the block is idle.
// Sequencing:
//   A push holds in_ready low until it completes, so a new push waits for the
//   last one: two reads of the row RAM, eight pair-side slots, each followed
//   by a write-back step when its count cell is updated (read-modify-write
//   through the single port of the count RAM and the one saturating adder),
//   and a final step to advance the column.
//   A read goes through ST_RD_ISSUE and puts its result in the output register from ST_RD_DATA.
//   A clear, and reset, sweep the count RAM one cell a cycle over all
//   2^(2*GRAY_BITS) cells (65536 with defaults), during which in_ready stays low.
// Stall: a waiting result is held in the output register; pushes and clears
//   proceed meanwhile, and a following read waits until the register frees.
module glcm_cooccurrence_accumulator_unit #(
    parameter int GRAY_BITS  = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  pixel_value,
    input  logic [7:0]  read_row,
    input  logic [7:0]  read_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] cell_count,
    output logic [7:0]  max_level
);

    localparam int CELL_BITS = 2 * GRAY_BITS;
    localparam int CELLS     = 1 << CELL_BITS;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int W_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_BITS  = (W_BITS > glcm_pkg::CFG_BITS) ? W_BITS : glcm_pkg::CFG_BITS;
    localparam logic [2:0] LAST_STEP = 3'd7;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UP_RD,
        ST_UR_RD,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_UPDATE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    state_t                         state_reg;
    logic [glcm_pkg::CFG_BITS-1:0]  width_reg;
    logic [GRAY_BITS-1:0]           pix_reg;
    logic [GRAY_BITS-1:0]           left_reg;
    logic [GRAY_BITS-1:0]           diag_reg;
    logic [GRAY_BITS-1:0]           up_reg;
    logic [GRAY_BITS-1:0]           upr_reg;
    logic [GRAY_BITS-1:0]           level_max_reg;
    logic [COL_BITS-1:0]            column_reg;
    logic                           past_first_reg;
    logic [2:0]                     step_reg;
    logic [CELL_BITS-1:0]           clr_addr_reg;
    logic [CELL_BITS-1:0]           rd_addr_reg;
    logic                           rd_oob_reg;
    logic                           out_valid_reg;
    logic [31:0]                    cell_count_reg;
    logic [7:0]                     max_level_reg;

    logic [CMP_BITS-1:0]   width_ext;
    logic [CMP_BITS-1:0]   eff_width;
    logic [CMP_BITS-1:0]   col_inc;
    logic                  row_end;
    logic                  col_nz;
    logic [GRAY_BITS-1:0]  nb;
    logic                  pair_en;
    logic                  same;
    logic                  step_on;
    glcm_pkg::inc_t        inc;
    logic [CELL_BITS-1:0]  pair_addr;
    logic [31:0]           count_field;

    logic                  cnt_we;
    logic [CELL_BITS-1:0]  cnt_addr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [COUNT_BITS-1:0] cnt_sum;

    logic                  row_we;
    logic [COL_BITS-1:0]   row_addr;
    logic [GRAY_BITS-1:0]  row_rdata;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_count = cell_count_reg;
    assign max_level  = max_level_reg;

    // effective width clamped to the supported range, and end-of-row test
    always_comb
    begin
        width_ext = CMP_BITS'(width_reg);
        if (width_ext < CMP_BITS'(2))
        begin
            eff_width = CMP_BITS'(2);
        end
        else if (width_ext > CMP_BITS'(MAX_WIDTH))
        begin
            eff_width = CMP_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        col_inc = CMP_BITS'(column_reg) + CMP_BITS'(1);
        row_end = (col_inc >= eff_width);
        col_nz  = (column_reg != '0);
    end

    // pair slot: step[2:1] picks the neighbor, step[0] the side of the pair
    always_comb
    begin
        case (step_reg[2:1])
            2'd0:
            begin
                nb      = left_reg;
                pair_en = col_nz;
            end
            2'd1:
            begin
                nb      = up_reg;
                pair_en = past_first_reg;
            end
            2'd2:
            begin
                nb      = diag_reg;
                pair_en = past_first_reg && col_nz;
            end
            default:
            begin
                nb      = upr_reg;
                pair_en = past_first_reg && !row_end;
            end
        endcase
        same      = (nb == pix_reg);
        // equal levels hit one cell: add two once, skip the mirrored side
        step_on   = pair_en && !(step_reg[0] && same);
        inc       = same ? glcm_pkg::INC_TWO : glcm_pkg::INC_ONE;
        pair_addr = step_reg[0] ? {nb, pix_reg} : {pix_reg, nb};
    end

    // count RAM port
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_addr  = pair_addr;
        cnt_wdata = cnt_sum;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_addr  = clr_addr_reg;
                cnt_wdata = '0;
            end
            ST_CNT_WR:
            begin
                cnt_we = 1'b1;
            end
            ST_RD_ISSUE, ST_RD_DATA:
            begin
                cnt_addr = rd_addr_reg;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // row RAM port: read above, read above-right, then overwrite above
    always_comb
    begin
        row_we   = 1'b0;
        row_addr = column_reg;
        case (state_reg)
            ST_UP_RD:
            begin
                row_addr = row_end ? column_reg : COL_BITS'(col_inc);
            end
            ST_UR_RD:
            begin
                row_we = 1'b1;
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

    // clamp wide counts to the 32-bit field
    always_comb
    begin
        if ((cnt_rdata >> glcm_pkg::FIELD_COUNT_BITS) != '0)
        begin
            count_field = '1;
        end
        else
        begin
            count_field = 32'(cnt_rdata);
        end
    end

    glcm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    glcm_ram #(
        .WIDTH (GRAY_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (pix_reg),
        .rdata (row_rdata)
    );

    glcm_sat_add #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sat_add (
        .value (cnt_rdata),
        .inc   (inc),
        .sum   (cnt_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            width_reg      <= glcm_pkg::CFG_BITS'(glcm_pkg::WIDTH_RESET);
            pix_reg        <= '0;
            left_reg       <= '0;
            diag_reg       <= '0;
            up_reg         <= '0;
            upr_reg        <= '0;
            level_max_reg  <= '0;
            column_reg     <= '0;
            past_first_reg <= 1'b0;
            step_reg       <= '0;
            clr_addr_reg   <= '0;
            rd_addr_reg    <= '0;
            rd_oob_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            cell_count_reg <= '0;
            max_level_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_data;
            end
            // a read in its last cycle decides the output register itself
            if (out_valid_reg && out_ready && (state_reg != ST_RD_DATA))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + CELL_BITS'(1);
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (glcm_pkg::cmd_t'(cmd))
                            glcm_pkg::CMD_PUSH:
                            begin
                                pix_reg   <= pixel_value[GRAY_BITS-1:0];
                                state_reg <= ST_UP_RD;
                            end
                            glcm_pkg::CMD_READ:
                            begin
                                rd_addr_reg <= {read_row[GRAY_BITS-1:0],
                                                read_col[GRAY_BITS-1:0]};
                                rd_oob_reg  <= ((read_row >> GRAY_BITS) != 8'd0) ||
                                               ((read_col >> GRAY_BITS) != 8'd0);
                                state_reg   <= ST_RD_ISSUE;
                            end
                            glcm_pkg::CMD_CLEAR:
                            begin
                                left_reg       <= '0;
                                diag_reg       <= '0;
                                column_reg     <= '0;
                                past_first_reg <= 1'b0;
                                level_max_reg  <= '0;
                                clr_addr_reg   <= '0;
                                state_reg      <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_UP_RD:
                begin
                    up_reg    <= row_rdata;
                    state_reg <= ST_UR_RD;
                end
                ST_UR_RD:
                begin
                    upr_reg   <= row_rdata;
                    step_reg  <= '0;
                    state_reg <= ST_CNT_RD;
                end
                ST_CNT_RD:
                begin
                    if (step_on)
                    begin
                        state_reg <= ST_CNT_WR;
                    end
                    else if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_CNT_WR:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_CNT_RD;
                    end
                end
                ST_UPDATE:
                begin
                    diag_reg <= up_reg;
                    left_reg <= pix_reg;
                    if (pix_reg > level_max_reg)
                    begin
                        level_max_reg <= pix_reg;
                    end
                    if (row_end)
                    begin
                        column_reg     <= '0;
                        past_first_reg <= 1'b1;
                    end
                    else
                    begin
                        column_reg <= COL_BITS'(col_inc);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        cell_count_reg <= rd_oob_reg ? 32'd0 : count_field;
                        max_level_reg  <= 8'(level_max_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RD_DATA)
        else $error("result raised without a read");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == glcm_pkg::CMD_CLEAR))
        |=> (state_reg == ST_CLEAR) && (clr_addr_reg == '0) && (level_max_reg == '0))
        else $error("clear did not restart image state");

    a_level_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && (cmd == glcm_pkg::CMD_CLEAR))
        |=> level_max_reg >= $past(level_max_reg))
        else $error("max level dropped without a clear");

    a_column_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE)
        |=> (column_reg == '0) || (column_reg == $past(column_reg) + COL_BITS'(1)))
        else $error("column position skipped");
`endif

endmodule
